// ----- hdl/mfred_pkg.sv -----
`timescale 1ns / 1ps

package mfred_pkg;

  localparam logic [7:0] HEAD_BYTE  = 8'h5A;
  localparam logic [7:0] TAIL_BYTE  = 8'h5B;
  localparam logic [7:0] MIN_LENGTH = 8'd6;

  localparam logic [7:0] CMD_PIR_RESULT  = 8'h08;
  localparam logic [7:0] CMD_VERSION     = 8'h00;
  localparam logic [7:0] CMD_CHECK_REPLY = 8'h42;
  localparam logic [7:0] CMD_STATUS      = 8'hC8;
  localparam logic [7:0] CMD_SHUTDOWN    = 8'hCA;

  localparam int BIT_POWER    = 0;
  localparam int BIT_HOME     = 1;
  localparam int BIT_DOORBELL = 2;
  localparam int BIT_PIR      = 3;
  localparam int BIT_WIFI     = 4;

  localparam int EV_PIR_RESULT = 0;
  localparam int EV_VERSION    = 1;
  localparam int EV_ACK        = 2;
  localparam int EV_POWER_KEY  = 3;
  localparam int EV_HOME_KEY   = 4;
  localparam int EV_DOORBELL   = 5;
  localparam int EV_PIR        = 6;
  localparam int EV_WIFI_WAKE  = 7;
  localparam int EV_POWEROFF   = 8;
  localparam int NUM_EVENTS    = 9;

  localparam logic       REQ_TICK      = 1'b1;
  localparam logic [7:0] HOLDOFF_RESET = 8'd3;
  localparam logic       REG_HOLDOFF   = 1'b0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                  load;
    logic [NUM_EVENTS-1:0] mask;
    logic [7:0]            value_a;
    logic [7:0]            value_b;
  } dec_t;

endpackage

// ----- hdl/mfred_parser.sv -----
`timescale 1ns / 1ps

module mfred_parser import mfred_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_item_t   item,
  input  logic [7:0] holdoff_cfg,
  output dec_t       dec,
  output logic       at_tail
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_CHECK  = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] d1_r, d1_nxt;
  logic [7:0] d2_r, d2_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [7:0] b;
  logic [7:0] pos_inc;
  logic       good_end;
  logic [NUM_EVENTS-1:0] mask;

  assign b       = item.rx_byte;
  assign pos_inc = pos_r + 8'd1;
  assign at_tail = (phase_r == PH_TAIL);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    good_end  = 1'b0;
    if (item.req_type != REQ_TICK) begin
      if (phase_r == PH_HUNT) begin
        if (b == HEAD_BYTE) begin
          phase_nxt = PH_LENGTH;
          pos_nxt   = 8'd1;
          sum_nxt   = 8'd0;
          cmd_nxt   = 8'd0;
          d1_nxt    = 8'd0;
          d2_nxt    = 8'd0;
        end
      end else begin
        if (pos_r == 8'd4) d1_nxt = b;
        if (pos_r == 8'd5) d2_nxt = b;
        unique case (phase_r)
          PH_LENGTH: begin
            if (b < MIN_LENGTH) begin
              phase_nxt = PH_HUNT;
              pos_nxt   = 8'd0;
            end else begin
              len_nxt   = b;
              sum_nxt   = b;
              phase_nxt = PH_BODY;
              pos_nxt   = 8'd2;
            end
          end
          PH_BODY: begin
            sum_nxt = sum_r + b;
            if (pos_r == 8'd3) cmd_nxt = b;
            pos_nxt = pos_inc;
            if (pos_inc == len_r - 8'd2) phase_nxt = PH_CHECK;
          end
          PH_CHECK: begin
            if (b != sum_r) begin
              phase_nxt = PH_HUNT;
              pos_nxt   = 8'd0;
            end else begin
              phase_nxt = PH_TAIL;
              pos_nxt   = pos_inc;
            end
          end
          PH_TAIL: begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
            good_end  = (b == TAIL_BYTE);
          end
          default: begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    mask     = '0;
    hold_nxt = hold_r;
    if (item.req_type == REQ_TICK) begin
      if (hold_r != 8'd0) hold_nxt = hold_r - 8'd1;
    end else if (good_end) begin
      unique case (cmd_r)
        CMD_PIR_RESULT: mask[EV_PIR_RESULT] = 1'b1;
        CMD_VERSION:    mask[EV_VERSION]    = 1'b1;
        CMD_CHECK_REPLY, CMD_STATUS: begin
          mask[EV_ACK]       = 1'b1;
          mask[EV_POWER_KEY] = d1_nxt[BIT_POWER];
          mask[EV_HOME_KEY]  = d1_nxt[BIT_HOME];
          if (d1_nxt[BIT_DOORBELL] && hold_r == 8'd0) begin
            mask[EV_DOORBELL] = 1'b1;
            hold_nxt          = holdoff_cfg;
          end
          mask[EV_PIR]       = d1_nxt[BIT_PIR];
          mask[EV_WIFI_WAKE] = d1_nxt[BIT_WIFI];
        end
        CMD_SHUTDOWN:   mask[EV_POWEROFF]   = 1'b1;
        default:        mask = '0;
      endcase
    end
  end

  assign dec.load    = acc && (mask != '0);
  assign dec.mask    = mask;
  assign dec.value_a = d1_nxt;
  assign dec.value_b = d2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= 8'd0;
      hold_r  <= 8'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      cmd_r <= cmd_nxt;
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
    end
  end

endmodule

// ----- hdl/mfred_emitter.sv -----
`timescale 1ns / 1ps

module mfred_emitter import mfred_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dec_t      dec,
  output logic      pending,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [NUM_EVENTS-1:0] mask_r, mask_nxt;
  logic [NUM_EVENTS-1:0] low_bit;
  logic [NUM_EVENTS-1:0] rest;
  logic [7:0]            va_r, vb_r;
  logic                  ov_r, ov_nxt;
  out_item_t             out_r;
  logic [3:0]            code;
  logic                  pop;

  assign low_bit = mask_r & (~mask_r + 1'b1);
  assign rest    = mask_r & ~low_bit;
  assign pending = (mask_r != '0);
  assign pop     = pending && (!ov_r || !out_stall);

  always_comb begin
    code = '0;
    for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
      if (mask_r[i]) code = 4'(i);
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    ov_nxt   = ov_r;
    if (pop) begin
      mask_nxt = rest;
      ov_nxt   = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
    if (dec.load) mask_nxt = dec.mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.load) begin
      va_r <= dec.value_a;
      vb_r <= dec.value_b;
    end
    if (pop) begin
      out_r.event_code <= code;
      out_r.value_a    <= va_r;
      out_r.value_b    <= vb_r;
      out_r.last       <= (rest == '0);
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/mcu_frame_receiver_event_decoder_core.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Payload     Handshake
// in_      input      in_item_t   in_valid / in_stall
// out_     output     out_item_t  out_valid / out_stall
// cfg_     input      APB write   cfg_psel, cfg_penable, cfg_pwrite, cfg_pready
//
// One input transaction is taken per cycle while in_stall is low; the parser updates
// in the cycle it is taken. A good frame end queues up to six events, which leave one
// per cycle while out_stall is low, through the event queue and then the output register.
// in_stall rises only while the parser waits for a tail byte and the previous frame's
// events are still queued; output stalls hold the output register.
// Reset is synchronous and clears the parser phase, hold-off counter and event queue.

module mcu_frame_receiver_event_decoder_core import mfred_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] holdoff_r;
  logic       acc;
  logic       at_tail;
  logic       pending;
  dec_t       dec;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HOLDOFF) ? {24'd0, holdoff_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= HOLDOFF_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_HOLDOFF) begin
      holdoff_r <= cfg_pwdata[7:0];
    end
  end

  assign in_stall = at_tail && pending;
  assign acc      = in_valid && !in_stall;

  mfred_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .item        (in_data),
    .holdoff_cfg (holdoff_r),
    .dec         (dec),
    .at_tail     (at_tail)
  );

  mfred_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .pending   (pending),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/frame_event_checker.sv -----
`timescale 1ns / 1ps

module frame_event_checker import mfred_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          events_pending
);

  localparam logic [2:0] HOLDOFF_ADDR = 3'(4 * REG_HOLDOFF);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_BODY,
    ST_SUM,
    ST_TAIL
  } rx_phase_t;

  rx_phase_t  rx_phase;
  logic [7:0] frame_len;
  logic [7:0] byte_pos;
  logic [7:0] run_sum;
  logic [7:0] cmd_byte;
  logic [7:0] data_first;
  logic [7:0] data_second;
  logic [7:0] holdoff_left;
  logic [7:0] holdoff_reg;

  out_item_t expected_events[$];

  task automatic report_mismatch(string msg);
    if (fail_count < 40) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic void add_event(int code);
    out_item_t ev;
    ev.event_code = 4'(code);
    ev.value_a    = data_first;
    ev.value_b    = data_second;
    ev.last       = 1'b0;
    expected_events.push_back(ev);
  endfunction

  // Expands a completed frame into its events and flags the final one.
  function automatic void decode_frame();
    int        start_size;
    out_item_t ev;
    start_size = expected_events.size();
    case (cmd_byte)
      CMD_PIR_RESULT: begin
        add_event(EV_PIR_RESULT);
      end
      CMD_VERSION: begin
        add_event(EV_VERSION);
      end
      CMD_CHECK_REPLY, CMD_STATUS: begin
        add_event(EV_ACK);
        if (data_first[BIT_POWER]) add_event(EV_POWER_KEY);
        if (data_first[BIT_HOME]) add_event(EV_HOME_KEY);
        if (data_first[BIT_DOORBELL] && holdoff_left == 8'd0) begin
          holdoff_left = holdoff_reg;
          add_event(EV_DOORBELL);
        end
        if (data_first[BIT_PIR]) add_event(EV_PIR);
        if (data_first[BIT_WIFI]) add_event(EV_WIFI_WAKE);
      end
      CMD_SHUTDOWN: begin
        add_event(EV_POWEROFF);
      end
      default: begin
      end
    endcase
    if (expected_events.size() > start_size) begin
      ev = expected_events.pop_back();
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
  endfunction

  function automatic void decode_rx_item(in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    if (it.req_type == REQ_TICK) begin
      if (holdoff_left != 8'd0) holdoff_left = holdoff_left - 8'd1;
      return;
    end
    if (rx_phase == ST_HUNT) begin
      if (b == HEAD_BYTE) begin
        rx_phase    = ST_LEN;
        byte_pos    = 8'd1;
        run_sum     = 8'd0;
        cmd_byte    = 8'd0;
        data_first  = 8'd0;
        data_second = 8'd0;
      end
      return;
    end
    if (byte_pos == 8'd4) data_first = b;
    if (byte_pos == 8'd5) data_second = b;
    case (rx_phase)
      ST_LEN: begin
        if (b < MIN_LENGTH) begin
          rx_phase = ST_HUNT;
          byte_pos = 8'd0;
        end else begin
          frame_len = b;
          run_sum   = b;
          rx_phase  = ST_BODY;
          byte_pos  = 8'd2;
        end
      end
      ST_BODY: begin
        run_sum = run_sum + b;
        if (byte_pos == 8'd3) cmd_byte = b;
        byte_pos = byte_pos + 8'd1;
        if (byte_pos == 8'(frame_len - 8'd2)) rx_phase = ST_SUM;
      end
      ST_SUM: begin
        if (b != run_sum) begin
          rx_phase = ST_HUNT;
          byte_pos = 8'd0;
        end else begin
          rx_phase = ST_TAIL;
          byte_pos = byte_pos + 8'd1;
        end
      end
      ST_TAIL: begin
        rx_phase = ST_HUNT;
        byte_pos = 8'd0;
        if (b == TAIL_BYTE) decode_frame();
      end
      default: begin
        rx_phase = ST_HUNT;
        byte_pos = 8'd0;
      end
    endcase
  endfunction

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event code %0d", got.event_code));
      return;
    end
    want = expected_events.pop_front();
    if (got.event_code !== want.event_code) begin
      report_mismatch($sformatf("event_code %0d, expected %0d",
                                got.event_code, want.event_code));
    end
    if (got.value_a !== want.value_a) begin
      report_mismatch($sformatf("value_a %h, expected %h (event %0d)",
                                got.value_a, want.value_a, want.event_code));
    end
    if (got.value_b !== want.value_b) begin
      report_mismatch($sformatf("value_b %h, expected %h (event %0d)",
                                got.value_b, want.value_b, want.event_code));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %b, expected %b (event %0d)",
                                got.last, want.last, want.event_code));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase     = ST_HUNT;
      frame_len    = 8'd0;
      byte_pos     = 8'd0;
      run_sum      = 8'd0;
      cmd_byte     = 8'd0;
      data_first   = 8'd0;
      data_second  = 8'd0;
      holdoff_left = 8'd0;
      holdoff_reg  = HOLDOFF_RESET;
      expected_events.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == HOLDOFF_ADDR) begin
        if (cfg_pwrite) begin
          holdoff_reg = cfg_pwdata[7:0];
        end else if (cfg_prdata[7:0] !== holdoff_reg) begin
          report_mismatch($sformatf("hold-off register reads %h, expected %h",
                                    cfg_prdata[7:0], holdoff_reg));
        end
      end
      if (out_valid && !out_stall) check_event(out_data);
      if (in_valid && !in_stall) decode_rx_item(in_data);
    end
    events_pending <= expected_events.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mfred_pkg::*;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TAIL
  } frame_fault_t;

  localparam logic       REQ_RX       = !REQ_TICK;
  localparam logic [2:0] HOLDOFF_ADDR = 3'(4 * REG_HOLDOFF);

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int         fail_count;
  int         events_pending;
  int         idle_mode;
  int         tick_odds;
  int         items_sent;
  logic       hold_long;
  logic [7:0] frame_body[$];

  mcu_frame_receiver_event_decoder_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  frame_event_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  always #5 clk = ~clk;

  initial begin : watchdog
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic int draw_wait();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 5))
      0: return CMD_PIR_RESULT;
      1: return CMD_VERSION;
      2: return CMD_CHECK_REPLY;
      3: return CMD_STATUS;
      4: return CMD_SHUTDOWN;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : receiver
    int   n;
    logic long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long && !long_done) begin
        n         = 300;
        long_done = 1'b1;
      end else begin
        n = draw_wait();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic offer(logic kind, logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, rx_byte: b};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [7:0] id, frame_fault_t fault,
                            logic [7:0] bad);
    logic [7:0] seq[$];
    logic [7:0] sum;
    seq = {HEAD_BYTE, 8'(6 + frame_body.size()), id, cmd};
    foreach (frame_body[k]) seq.push_back(frame_body[k]);
    sum = 8'd0;
    for (int k = 1; k < seq.size(); k++) sum = sum + seq[k];
    if (fault == FRAME_BAD_SUM) begin
      seq.push_back((bad != sum) ? bad : (sum ^ 8'h01));
    end else begin
      seq.push_back(sum);
    end
    if (fault == FRAME_BAD_TAIL) begin
      seq.push_back((bad != TAIL_BYTE) ? bad : ~TAIL_BYTE);
    end else begin
      seq.push_back(TAIL_BYTE);
    end
    foreach (seq[k]) begin
      offer(REQ_RX, seq[k]);
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) begin
        offer(REQ_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic random_traffic(int target);
    int           r;
    int           n;
    frame_fault_t fault;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        offer(REQ_TICK, 8'($urandom));
      end else if (r < 17) begin
        offer(REQ_RX, 8'($urandom));
      end else if (r < 23) begin
        offer(REQ_RX, HEAD_BYTE);
        offer(REQ_RX, 8'($urandom_range(0, MIN_LENGTH - 1)));
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
        frame_body = {};
        repeat (n) frame_body.push_back(8'($urandom));
        fault = (r < 27) ? FRAME_BAD_SUM : (r < 31) ? FRAME_BAD_TAIL : FRAME_GOOD;
        send_frame(pick_command(), 8'($urandom), fault, 8'($urandom));
      end
    end
  endtask

  task automatic cfg_access(logic wr, logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= HOLDOFF_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] setting;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_long   = 1'b0;
    items_sent  = 0;
    idle_mode   = 0;
    tick_odds   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, 32'd0);
    offer(REQ_TICK, 8'hFF);
    offer(REQ_RX, 8'h00);
    offer(REQ_RX, HEAD_BYTE);
    offer(REQ_RX, MIN_LENGTH - 8'd1);
    frame_body = {8'h1F};
    send_frame(CMD_STATUS, 8'h00, FRAME_GOOD, 8'h00);
    // The doorbell bit here falls inside the hold-off window and is dropped.
    frame_body = {8'h04, 8'h80};
    send_frame(CMD_CHECK_REPLY, 8'hFF, FRAME_GOOD, 8'h00);
    // A head byte that breaks a frame must not start a new one.
    frame_body = {};
    send_frame(CMD_SHUTDOWN, 8'h11, FRAME_BAD_SUM, HEAD_BYTE);
    send_frame(CMD_VERSION, 8'hFF, FRAME_GOOD, 8'h00);
    send_frame(CMD_PIR_RESULT, 8'h22, FRAME_BAD_TAIL, HEAD_BYTE);

    idle_mode = 2;
    tick_odds = 8;
    random_traffic(items_sent + 15);

    for (int i = 0; i < 4; i++) begin
      case (i)
        0: setting = 8'd0;
        1: setting = 8'd255;
        2: setting = 8'd1;
        default: setting = 8'($urandom_range(2, 254));
      endcase
      wait_idle();
      cfg_access(1'b1, {24'($urandom), setting});
      cfg_access(1'b0, 32'd0);
      idle_mode = (i + 1) % 3;
      tick_odds = 6;
      random_traffic(items_sent + 30);
      if (i == 2) begin
        // Hold the result side off while back-to-back reports pile up behind it.
        idle_mode = 0;
        tick_odds = 0;
        hold_long <= 1'b1;
        frame_body = {8'h1F};
        repeat (5) send_frame(CMD_STATUS, 8'h5A, FRAME_GOOD, 8'h00);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 5000 && events_pending != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && events_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- mcu_frame_receiver_event_decoder_core.f -----
hdl/mfred_pkg.sv
hdl/mfred_parser.sv
hdl/mfred_emitter.sv
hdl/mcu_frame_receiver_event_decoder_core.sv
sim/frame_event_checker.sv
sim/tb_top.sv
